// ===== hw/rtl/vds_pkg.sv =====
// shared widths and constants for the vertex degree statistics block
`timescale 1ns / 1ps
package vds_pkg;
  localparam int ID_W      = 16;
  localparam int TOT_W     = 48;
  localparam int SQ_W      = 80;
  localparam int VAR_W     = 96;
  localparam int RAD_W     = 128;
  localparam int ROOT_W    = 64;
  localparam int QUO_W     = 64;
  localparam int DEG_OUT_W = 24;
  localparam int AVG_OUT_W = 40;
  localparam int FRAC_W    = 16;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_REPORT = 1'b1;
endpackage

// ===== hw/rtl/vds_front.sv =====
// front end: classifies incoming requests and pushes edges and reports to the queue
`timescale 1ns / 1ps
module vds_front #(
  parameter int AW = 16
) (
  input  logic                      edge_valid,
  output logic                      edge_stall,
  input  logic                      op,
  input  logic [vds_pkg::ID_W-1:0]  src_vertex,
  input  logic [vds_pkg::ID_W-1:0]  n,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [AW:0]               q_wdata
);
  import vds_pkg::*;

  logic keep;

  always_comb begin
    keep = (op == OP_REPORT) || ((src_vertex != '0) && (src_vertex <= n));
    edge_stall = q_full;
    q_push = edge_valid && !q_full && keep;
    q_wdata = {op, AW'(src_vertex)};
  end
endmodule

// ===== hw/rtl/vds_fifo.sv =====
// short request queue between front and back
`timescale 1ns / 1ps
module vds_fifo #(
  parameter int W = 17
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);
  import vds_pkg::*;

  logic [W-1:0]       slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr;
  logic [Q_PTR_W-1:0] rptr;
  logic [Q_PTR_W:0]   count;

  assign full  = (count == (Q_PTR_W + 1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ===== hw/rtl/vds_back.sv =====
// back end: degree store, edge increments, report scan and clearing sweeps
`timescale 1ns / 1ps
module vds_back #(
  parameter int AW          = 16,
  parameter int DEGREE_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [vds_pkg::ID_W-1:0]    n,
  input  logic                        q_empty,
  input  logic [AW:0]                 q_rdata,
  output logic                        q_pop,
  input  logic                        stats_ready,
  output logic                        stats_start,
  output logic [DEGREE_BITS-1:0]      acc_max,
  output logic [DEGREE_BITS-1:0]      acc_min,
  output logic [vds_pkg::TOT_W-1:0]   acc_total,
  output logic [vds_pkg::SQ_W-1:0]    acc_sumsq
);
  import vds_pkg::*;

  typedef enum logic [5:0] {
    B_CLEAR = 6'b000001,
    B_IDLE  = 6'b000010,
    B_INC   = 6'b000100,
    B_SCAN  = 6'b001000,
    B_DRAIN = 6'b010000,
    B_HAND  = 6'b100000
  } back_state_t;

  localparam logic [DEGREE_BITS-1:0] DEG_MAX  = '1;
  localparam logic [AW-1:0]          LAST_ADR = AW'(2 ** AW - 1);

  logic [DEGREE_BITS-1:0]   mem [2 ** AW];
  back_state_t              state;
  logic [AW-1:0]            clr_addr;
  logic [AW-1:0]            e_addr;
  logic [AW-1:0]            a1;
  logic                     p1;
  logic                     p2;
  logic                     in_rng;
  logic [ID_W-1:0]          cnt;
  logic [ID_W-1:0]          hi_mark;
  logic [ID_W-1:0]          scan_last;
  logic [DEGREE_BITS-1:0]   rdata;
  logic [2*DEGREE_BITS-1:0] sq;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [DEGREE_BITS-1:0]   mem_wdata;
  logic [AW-1:0]            mem_raddr;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = a1;
    mem_wdata = '0;
    mem_raddr = q_rdata[AW-1:0];
    q_pop     = 1'b0;
    stats_start = 1'b0;
    case (state)
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      B_IDLE: begin
        q_pop = !q_empty;
      end
      B_INC: begin
        mem_we    = 1'b1;
        mem_waddr = e_addr;
        mem_wdata = (rdata == DEG_MAX) ? rdata : rdata + 1'b1;
      end
      B_SCAN: begin
        mem_raddr = AW'(cnt);
      end
      B_HAND: begin
        stats_start = stats_ready;
      end
      default: begin
      end
    endcase
    if (p1) begin
      mem_we    = 1'b1;
      mem_waddr = a1;
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (p1 && in_rng) begin
      if (rdata > acc_max) begin
        acc_max <= rdata;
      end
      if (rdata < acc_min) begin
        acc_min <= rdata;
      end
      acc_total <= acc_total + TOT_W'(rdata);
      sq <= rdata * rdata;
    end
    if (p2) begin
      acc_sumsq <= acc_sumsq + SQ_W'(sq);
    end
    if (state == B_IDLE && !q_empty) begin
      e_addr    <= q_rdata[AW-1:0];
      acc_max   <= '0;
      acc_min   <= '1;
      acc_total <= '0;
      acc_sumsq <= '0;
    end
    if (state == B_SCAN) begin
      a1     <= AW'(cnt);
      in_rng <= (cnt <= n);
    end
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
      cnt      <= '0;
      hi_mark  <= '0;
      p1       <= 1'b0;
      p2       <= 1'b0;
    end else begin
      p1 <= (state == B_SCAN);
      p2 <= p1 && in_rng;
      case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADR) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!q_empty) begin
            if (q_rdata[AW] == OP_REPORT) begin
              cnt       <= ID_W'(1);
              scan_last <= (hi_mark > n) ? hi_mark : n;
              hi_mark   <= '0;
              state     <= ((n == '0) && (hi_mark == '0)) ? B_HAND : B_SCAN;
            end else begin
              if (ID_W'(q_rdata[AW-1:0]) > hi_mark) begin
                hi_mark <= ID_W'(q_rdata[AW-1:0]);
              end
              state <= B_INC;
            end
          end
        end
        B_INC: begin
          state <= B_IDLE;
        end
        B_SCAN: begin
          if (cnt == scan_last) begin
            state <= B_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        B_DRAIN: begin
          if (!p1 && !p2) begin
            state <= B_HAND;
          end
        end
        B_HAND: begin
          if (stats_ready) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== hw/rtl/vds_stats.sv =====
// serial multiply, square root and divide that turn the sums into the result
`timescale 1ns / 1ps
module vds_stats #(
  parameter int DEGREE_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            ready,
  input  logic [vds_pkg::ID_W-1:0]        n,
  input  logic [DEGREE_BITS-1:0]          in_max,
  input  logic [DEGREE_BITS-1:0]          in_min,
  input  logic [vds_pkg::TOT_W-1:0]       in_total,
  input  logic [vds_pkg::SQ_W-1:0]        in_sumsq,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [vds_pkg::DEG_OUT_W-1:0]   peak_degree,
  output logic [vds_pkg::DEG_OUT_W-1:0]   low_degree,
  output logic [vds_pkg::AVG_OUT_W-1:0]   mean_degree_q16,
  output logic [vds_pkg::AVG_OUT_W-1:0]   std_dev_q16
);
  import vds_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MULA = 6'b000010,
    S_MULB = 6'b000100,
    S_SQRT = 6'b001000,
    S_DIVA = 6'b010000,
    S_DIVB = 6'b100000
  } stats_state_t;

  localparam logic [5:0] MULA_LAST = 6'(ID_W - 1);
  localparam logic [5:0] MULB_LAST = 6'(TOT_W - 1);
  localparam logic [5:0] SQRT_LAST = 6'(ROOT_W - 1);
  localparam logic [5:0] DIV_LAST  = 6'(QUO_W - 1);

  stats_state_t           state;
  logic [5:0]             cnt;
  logic [ID_W-1:0]        n_r;
  logic [TOT_W-1:0]       total_r;
  logic [DEGREE_BITS-1:0] max_r;
  logic [DEGREE_BITS-1:0] min_r;
  logic [VAR_W-1:0]       acc;
  logic [VAR_W-1:0]       nss;
  logic [VAR_W-1:0]       mc;
  logic [TOT_W-1:0]       mp;
  logic [VAR_W-1:0]       add;
  logic [RAD_W-1:0]       xs;
  logic [ROOT_W+1:0]      rem;
  logic [ROOT_W+3:0]      rem2;
  logic [ROOT_W+3:0]      trial;
  logic                   sq_ge;
  logic [ROOT_W-1:0]      root;
  logic [ROOT_W-1:0]      root_next;
  logic [QUO_W-1:0]       dq;
  logic [ID_W-1:0]        drem;
  logic [ID_W:0]          dr2;
  logic                   dv_ge;
  logic [QUO_W-1:0]       quot;

  function automatic logic [AVG_OUT_W-1:0] sat_avg(input logic [QUO_W-1:0] v);
    return (v[QUO_W-1:AVG_OUT_W] != '0) ? '1 : v[AVG_OUT_W-1:0];
  endfunction

  function automatic logic [DEG_OUT_W-1:0] sat_deg(input logic [DEGREE_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w[31:DEG_OUT_W] != '0) ? '1 : w[DEG_OUT_W-1:0];
  endfunction

  always_comb begin
    ready     = (state == S_IDLE) && !result_valid;
    add       = acc + (mp[0] ? mc : '0);
    rem2      = {rem, xs[RAD_W-1 -: 2]};
    trial     = {2'b00, root, 2'b01};
    sq_ge     = (rem2 >= trial);
    root_next = {root[ROOT_W-2:0], sq_ge};
    dr2       = {drem, dq[QUO_W-1]};
    dv_ge     = (dr2 >= {1'b0, n_r});
    quot      = {dq[QUO_W-2:0], dv_ge};
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          n_r     <= n;
          total_r <= in_total;
          max_r   <= in_max;
          min_r   <= in_min;
          acc     <= '0;
          mc      <= VAR_W'(in_sumsq);
          mp      <= TOT_W'(n);
        end
      end
      S_MULA: begin
        acc <= add;
        mc  <= mc << 1;
        mp  <= mp >> 1;
        if (cnt == MULA_LAST) begin
          nss <= add;
          acc <= '0;
          mc  <= VAR_W'(total_r);
          mp  <= total_r;
        end
      end
      S_MULB: begin
        acc <= add;
        mc  <= mc << 1;
        mp  <= mp >> 1;
        if (cnt == MULB_LAST) begin
          xs   <= {nss - add, 32'b0};
          rem  <= '0;
          root <= '0;
        end
      end
      S_SQRT: begin
        xs   <= xs << 2;
        rem  <= sq_ge ? (ROOT_W + 2)'(rem2 - trial) : (ROOT_W + 2)'(rem2);
        root <= root_next;
        if (cnt == SQRT_LAST) begin
          dq   <= {total_r, FRAC_W'(0)};
          drem <= '0;
        end
      end
      S_DIVA: begin
        drem <= dv_ge ? ID_W'(dr2 - {1'b0, n_r}) : ID_W'(dr2);
        dq   <= quot;
        if (cnt == DIV_LAST) begin
          mean_degree_q16 <= sat_avg(quot);
          dq   <= root;
          drem <= '0;
        end
      end
      S_DIVB: begin
        drem <= dv_ge ? ID_W'(dr2 - {1'b0, n_r}) : ID_W'(dr2);
        dq   <= quot;
        if (cnt == DIV_LAST) begin
          std_dev_q16 <= sat_avg(quot);
          peak_degree <= sat_deg(max_r);
          low_degree  <= sat_deg(min_r);
        end
      end
      default: begin
      end
    endcase
    if (state == S_IDLE && start && n == '0) begin
      peak_degree     <= '0;
      low_degree      <= '0;
      mean_degree_q16 <= '0;
      std_dev_q16     <= '0;
    end
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      cnt <= cnt + 1'b1;
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (start) begin
            if (n == '0) begin
              result_valid <= 1'b1;
            end else begin
              state <= S_MULA;
            end
          end
        end
        S_MULA: begin
          if (cnt == MULA_LAST) begin
            cnt   <= '0;
            state <= S_MULB;
          end
        end
        S_MULB: begin
          if (cnt == MULB_LAST) begin
            cnt   <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (cnt == SQRT_LAST) begin
            cnt   <= '0;
            state <= S_DIVA;
          end
        end
        S_DIVA: begin
          if (cnt == DIV_LAST) begin
            cnt   <= '0;
            state <= S_DIVB;
          end
        end
        S_DIVB: begin
          if (cnt == DIV_LAST) begin
            cnt          <= '0;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== hw/rtl/vertex_degree_statistics.sv =====
// top level of the vertex out-degree statistics block
`timescale 1ns / 1ps
// Edge requests are taken one per cycle into a four-entry queue while it has room; the back
// end retires an edge by a store read, then a write of the incremented counter, and takes
// no new edge before that write, even in a long edge burst. Ids of zero or above the vertex
// count are dropped at the front and cost no back-end time. A report scans vertices 1 to n
// at one per cycle, clearing each counter as it is read; when the vertex count has shrunk
// since the last report the scan runs on up to the highest id counted since then, clearing
// those counters without using them. It then hands the sums to a serial arithmetic unit
// that runs two multiplies, a square root and two divides in turn before the result
// appears; edges queued behind a report proceed meanwhile. After reset every store
// address, MAX_VERTICES rounded up to a power of two, is swept to zero; requests
// meanwhile only fill the queue.
module vertex_degree_statistics #(
  parameter int MAX_VERTICES = 65536,
  parameter int DEGREE_BITS  = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  vertex_count_we,
  input  logic [vds_pkg::ID_W-1:0]              vertex_count_data,
  input  logic                                  edge_valid,
  output logic                                  edge_stall,
  input  logic                                  op,
  input  logic [vds_pkg::ID_W-1:0]              src_vertex,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [vds_pkg::DEG_OUT_W-1:0]         peak_degree,
  output logic [vds_pkg::DEG_OUT_W-1:0]         low_degree,
  output logic [vds_pkg::AVG_OUT_W-1:0]         mean_degree_q16,
  output logic [vds_pkg::AVG_OUT_W-1:0]         std_dev_q16
);
  import vds_pkg::*;

  localparam int          AW   = $clog2(MAX_VERTICES);
  localparam logic [31:0] NMAX = 32'(MAX_VERTICES - 1);

  logic [ID_W-1:0]        vertex_count;
  logic [ID_W-1:0]        n;
  logic                   q_full;
  logic                   q_push;
  logic [AW:0]            q_wdata;
  logic                   q_empty;
  logic                   q_pop;
  logic [AW:0]            q_rdata;
  logic                   stats_ready;
  logic                   stats_start;
  logic [DEGREE_BITS-1:0] acc_max;
  logic [DEGREE_BITS-1:0] acc_min;
  logic [TOT_W-1:0]       acc_total;
  logic [SQ_W-1:0]        acc_sumsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= ID_W'(1);
    end else if (vertex_count_we) begin
      vertex_count <= vertex_count_data;
    end
  end

  assign n = (32'(vertex_count) > NMAX) ? NMAX[ID_W-1:0] : vertex_count;

  vds_front #(.AW(AW)) u_front (
    .edge_valid (edge_valid),
    .edge_stall (edge_stall),
    .op         (op),
    .src_vertex (src_vertex),
    .n          (n),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  vds_fifo #(.W(AW + 1)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  vds_back #(.AW(AW), .DEGREE_BITS(DEGREE_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .n           (n),
    .q_empty     (q_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .stats_ready (stats_ready),
    .stats_start (stats_start),
    .acc_max     (acc_max),
    .acc_min     (acc_min),
    .acc_total   (acc_total),
    .acc_sumsq   (acc_sumsq)
  );

  vds_stats #(.DEGREE_BITS(DEGREE_BITS)) u_stats (
    .clk             (clk),
    .rst             (rst),
    .start           (stats_start),
    .ready           (stats_ready),
    .n               (n),
    .in_max          (acc_max),
    .in_min          (acc_min),
    .in_total        (acc_total),
    .in_sumsq        (acc_sumsq),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .peak_degree     (peak_degree),
    .low_degree      (low_degree),
    .mean_degree_q16 (mean_degree_q16),
    .std_dev_q16     (std_dev_q16)
  );
endmodule
